/* rtl/core/qnv_pkg.sv */
// Package with shared constants for the quaternion north vector core.
package qnv_pkg;

  // Default component width of one quaternion element.
  localparam int QuatBitsDefault = 16;
  // Width of the field strength register.
  localparam int FieldBits = 7;
  // Field strength after reset, in whole microtesla.
  localparam logic [FieldBits-1:0] FieldReset = 7'd45;
  // Width of the scale K = 256 * F.
  localparam int KBits = FieldBits + 8;
  // Number of quotient bits produced by the divider chain.
  localparam int QuoBits = 16;
  // Width of one result field.
  localparam int MagBits = 16;

  // Configuration register indexes.
  localparam logic CfgEnable = 1'b0;
  localparam logic CfgField  = 1'b1;

endpackage

/* rtl/core/quaternion_north_vector_core.sv */
// Top level of the quaternion north vector core.
// Turns an orientation quaternion (quat_x, quat_y, quat_z, quat_w) into the
// north field vector seen in device space, in units of 1/256 microtesla.
// Input words arrive on in_valid/in_ready and results leave on
// out_valid/out_ready; each field is a port of its own.
// The configuration port (cfg_we, cfg_index, cfg_data) sets enable and the
// field strength; while disabled, input words are taken and dropped.
// Three stages form products, norm and scaled
// numerators, then a row of 16 divider cells each yields one quotient bit,
// one stage rounds, the word is written into the buffer, and the output
// register holds the word.
// One word is accepted per clock cycle when the receiver keeps up.
// Words in flight are counted against a 32-word skid buffer, more than the
// pipeline holds, so the pipeline moves every cycle and in_ready falls only
// when the buffer could not take every word already under way.
// A quaternion with all components zero yields zero fields and zero_norm.
// Reset clears the pipeline, the buffer, enable and sets the field to 45.
module quaternion_north_vector_core
  import qnv_pkg::*;
#(
  parameter int QuatBits = QuatBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [QuatBits-1:0] quat_x,
  input  logic signed [QuatBits-1:0] quat_y,
  input  logic signed [QuatBits-1:0] quat_z,
  input  logic signed [QuatBits-1:0] quat_w,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [MagBits-1:0]  mag_x,
  output logic signed [MagBits-1:0]  mag_y,
  output logic signed [MagBits-1:0]  mag_z,
  output logic                       zero_norm,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [FieldBits-1:0]       cfg_data
);

  localparam int NumBits  = 2 * QuatBits + 3 + KBits;
  localparam int FifoSize = 32;
  localparam int PtrBits  = $clog2(FifoSize);
  localparam int WordBits = 3 * MagBits + 1;

  typedef logic [WordBits-1:0] word_t;

  // Configuration registers.
  logic                 enable;
  logic [FieldBits-1:0] field;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      field  <= FieldReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgEnable: enable <= cfg_data[0];
        CfgField:  field  <= cfg_data;
        default:   ;
      endcase
    end
  end

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // Front stages.
  logic               p_valid, p_zero;
  logic [NumBits-1:0] p_norm, p_m0, p_m1, p_m2;
  logic [2:0]         p_neg;

  qnv_prep #(.QuatBits(QuatBits), .NumBits(NumBits)) u_prep (
    .clk, .rst,
    .in_valid (in_fire && enable),
    .qx (quat_x), .qy (quat_y), .qz (quat_z), .qw (quat_w),
    .k ({field, 8'd0}),
    .out_valid (p_valid), .out_zero (p_zero), .norm (p_norm),
    .mag0 (p_m0), .mag1 (p_m1), .mag2 (p_m2), .neg (p_neg)
  );

  // Row of divider cells, one quotient bit each, most significant first.
  logic               c_valid [QuoBits+1];
  logic               c_zero  [QuoBits+1];
  logic [NumBits-1:0] c_norm  [QuoBits+1];
  logic [NumBits-1:0] c_r0    [QuoBits+1];
  logic [NumBits-1:0] c_r1    [QuoBits+1];
  logic [NumBits-1:0] c_r2    [QuoBits+1];
  logic [QuoBits-1:0] c_q0    [QuoBits+1];
  logic [QuoBits-1:0] c_q1    [QuoBits+1];
  logic [QuoBits-1:0] c_q2    [QuoBits+1];
  logic [2:0]         c_neg   [QuoBits+1];

  assign c_valid[0] = p_valid;
  assign c_zero[0]  = p_zero;
  assign c_norm[0]  = p_norm;
  assign c_r0[0]    = p_m0;
  assign c_r1[0]    = p_m1;
  assign c_r2[0]    = p_m2;
  assign c_q0[0]    = '0;
  assign c_q1[0]    = '0;
  assign c_q2[0]    = '0;
  assign c_neg[0]   = p_neg;

  for (genvar g = 0; g < QuoBits; g++) begin : g_cell
    qnv_div_cell #(.NumBits(NumBits), .Shift(QuoBits - 1 - g)) u_cell (
      .clk, .rst,
      .in_valid (c_valid[g]), .in_zero (c_zero[g]), .in_norm (c_norm[g]),
      .in_rem0 (c_r0[g]), .in_rem1 (c_r1[g]), .in_rem2 (c_r2[g]),
      .in_q0 (c_q0[g]), .in_q1 (c_q1[g]), .in_q2 (c_q2[g]), .in_neg (c_neg[g]),
      .out_valid (c_valid[g+1]), .out_zero (c_zero[g+1]), .out_norm (c_norm[g+1]),
      .out_rem0 (c_r0[g+1]), .out_rem1 (c_r1[g+1]), .out_rem2 (c_r2[g+1]),
      .out_q0 (c_q0[g+1]), .out_q1 (c_q1[g+1]), .out_q2 (c_q2[g+1]),
      .out_neg (c_neg[g+1])
    );
  end

  // Rounding to nearest, ties away from zero, then the sign.
  function automatic logic [MagBits-1:0] round_sign(
    input logic [QuoBits-1:0] q,
    input logic [NumBits-1:0] r,
    input logic [NumBits-1:0] n,
    input logic               s
  );
    logic [MagBits-1:0] m;
    m = MagBits'(q) + MagBits'({r, 1'b0} >= {1'b0, n});
    return s ? MagBits'(-m) : m;
  endfunction

  logic  f_valid;
  word_t f_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= c_valid[QuoBits];
    end
    if (c_zero[QuoBits]) begin
      f_word <= {{(3 * MagBits){1'b0}}, 1'b1};
    end else begin
      f_word <= {round_sign(c_q0[QuoBits], c_r0[QuoBits], c_norm[QuoBits], c_neg[QuoBits][0]),
                 round_sign(c_q1[QuoBits], c_r1[QuoBits], c_norm[QuoBits], c_neg[QuoBits][1]),
                 round_sign(c_q2[QuoBits], c_r2[QuoBits], c_norm[QuoBits], c_neg[QuoBits][2]),
                 1'b0};
    end
  end

  // Skid buffer for finished words; credit counts words in flight too.
  word_t              fifo_mem [FifoSize];
  logic [PtrBits-1:0] wr_ptr, rd_ptr;
  logic [PtrBits:0]   fifo_count;
  logic [PtrBits:0]   credit;
  logic               pop, launch;
  word_t              out_word;

  assign launch   = in_fire && enable;
  assign pop      = out_valid && out_ready;
  assign in_ready = credit < (PtrBits + 1)'(FifoSize);

  always_ff @(posedge clk) begin
    if (f_valid) begin
      fifo_mem[wr_ptr] <= f_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      credit     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (f_valid) wr_ptr <= wr_ptr + 1'b1;
      credit <= credit + (PtrBits + 1)'(launch)
              - (PtrBits + 1)'(pop);
      // Output register refill from the buffer.
      if (!out_valid || out_ready) begin
        if (fifo_count != '0) begin
          out_valid  <= 1'b1;
          out_word   <= fifo_mem[rd_ptr];
          rd_ptr     <= rd_ptr + 1'b1;
          fifo_count <= fifo_count + (PtrBits + 1)'(f_valid) - 1'b1;
        end else begin
          out_valid  <= 1'b0;
          fifo_count <= fifo_count + (PtrBits + 1)'(f_valid);
        end
      end else begin
        fifo_count <= fifo_count + (PtrBits + 1)'(f_valid);
      end
    end
  end

  assign mag_x     = out_word[WordBits-1 -: MagBits];
  assign mag_y     = out_word[2*MagBits -: MagBits];
  assign mag_z     = out_word[MagBits -: MagBits];
  assign zero_norm = out_word[0];

endmodule

/* rtl/core/qnv_prep.sv */
// Front stages: products of the components, norm and scaled numerators.
module qnv_prep
  import qnv_pkg::*;
#(
  parameter int QuatBits = QuatBitsDefault,
  parameter int NumBits  = 2 * QuatBits + 3 + KBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [QuatBits-1:0] qx,
  input  logic signed [QuatBits-1:0] qy,
  input  logic signed [QuatBits-1:0] qz,
  input  logic signed [QuatBits-1:0] qw,
  input  logic [KBits-1:0]          k,
  output logic                      out_valid,
  output logic                      out_zero,
  output logic [NumBits-1:0]        norm,
  output logic [NumBits-1:0]        mag0,
  output logic [NumBits-1:0]        mag1,
  output logic [NumBits-1:0]        mag2,
  output logic [2:0]                neg
);

  localparam int PBits = 2 * QuatBits + 1;
  localparam int SBits = 2 * QuatBits + 3;

  // Stage one: the eight pair products.
  logic signed [PBits-1:0] pxy, pwz, pyz, pwx, pxx, pyy, pzz, pww;
  logic                    v1;
  logic [KBits-1:0]        k1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    pxy <= PBits'(qx * qy);
    pwz <= PBits'(qw * qz);
    pyz <= PBits'(qy * qz);
    pwx <= PBits'(qw * qx);
    pxx <= PBits'(qx * qx);
    pyy <= PBits'(qy * qy);
    pzz <= PBits'(qz * qz);
    pww <= PBits'(qw * qw);
    k1  <= k;
  end

  // Stage two: sums for the norm and the three numerators.
  logic signed [SBits-1:0] s_n, s_x, s_y, s_z;
  logic                    v2;
  logic [KBits-1:0]        k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s_n <= SBits'(pxx) + SBits'(pyy) + SBits'(pzz) + SBits'(pww);
    s_x <= (SBits'(pxy) + SBits'(pwz)) <<< 1;
    s_y <= SBits'(pww) + SBits'(pyy) - SBits'(pxx) - SBits'(pzz);
    s_z <= (SBits'(pyz) - SBits'(pwx)) <<< 1;
    k2  <= k1;
  end

  // Stage three: magnitudes scaled by K, with their signs kept aside.
  logic [SBits-1:0] a_x, a_y, a_z;

  always_comb begin
    a_x = s_x[SBits-1] ? SBits'(-s_x) : SBits'(s_x);
    a_y = s_y[SBits-1] ? SBits'(-s_y) : SBits'(s_y);
    a_z = s_z[SBits-1] ? SBits'(-s_z) : SBits'(s_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    norm     <= NumBits'(unsigned'(s_n));
    mag0     <= NumBits'(a_x) * NumBits'(k2);
    mag1     <= NumBits'(a_y) * NumBits'(k2);
    mag2     <= NumBits'(a_z) * NumBits'(k2);
    neg      <= {s_z[SBits-1], s_y[SBits-1], s_x[SBits-1]};
    out_zero <= (s_n == '0);
  end

endmodule

/* rtl/core/qnv_div_cell.sv */
// One cell of the divider chain: one restoring step for the three numerators.
module qnv_div_cell
  import qnv_pkg::*;
#(
  parameter int NumBits = 50,
  parameter int Shift   = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_zero,
  input  logic [NumBits-1:0] in_norm,
  input  logic [NumBits-1:0] in_rem0,
  input  logic [NumBits-1:0] in_rem1,
  input  logic [NumBits-1:0] in_rem2,
  input  logic [QuoBits-1:0] in_q0,
  input  logic [QuoBits-1:0] in_q1,
  input  logic [QuoBits-1:0] in_q2,
  input  logic [2:0]         in_neg,
  output logic               out_valid,
  output logic               out_zero,
  output logic [NumBits-1:0] out_norm,
  output logic [NumBits-1:0] out_rem0,
  output logic [NumBits-1:0] out_rem1,
  output logic [NumBits-1:0] out_rem2,
  output logic [QuoBits-1:0] out_q0,
  output logic [QuoBits-1:0] out_q1,
  output logic [QuoBits-1:0] out_q2,
  output logic [2:0]         out_neg
);

  localparam int WBits = NumBits + QuoBits;

  // Divisor shifted to this cell's quotient bit.
  logic [WBits-1:0] d;
  logic             t0, t1, t2;

  always_comb begin
    d  = WBits'(in_norm) << Shift;
    t0 = d <= WBits'(in_rem0);
    t1 = d <= WBits'(in_rem1);
    t2 = d <= WBits'(in_rem2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_zero <= in_zero;
    out_norm <= in_norm;
    out_neg  <= in_neg;
    out_rem0 <= t0 ? NumBits'(WBits'(in_rem0) - d) : in_rem0;
    out_rem1 <= t1 ? NumBits'(WBits'(in_rem1) - d) : in_rem1;
    out_rem2 <= t2 ? NumBits'(WBits'(in_rem2) - d) : in_rem2;
    out_q0   <= in_q0 | (QuoBits'(t0) << Shift);
    out_q1   <= in_q1 | (QuoBits'(t1) << Shift);
    out_q2   <= in_q2 | (QuoBits'(t2) << Shift);
  end

endmodule

/* bench/tb_quaternion_north_vector_core.sv */
// Self-checking testbench for the quaternion north vector core.
`timescale 1ns / 1ps

module tb_quaternion_north_vector_core;
  import qnv_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [MagBits-1:0] mx;
    logic signed [MagBits-1:0] my;
    logic signed [MagBits-1:0] mz;
    logic                      zn;
  } north_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [MagBits-1:0] mag_x, mag_y, mag_z;
  logic zero_norm;
  logic cfg_we, cfg_index;
  logic [FieldBits-1:0] cfg_data;

  quat_t  quat_pending[$];
  north_t north_expected[$];
  logic   en_copy;
  logic [FieldBits-1:0] field_copy;
  int     tx_idle_pct, rx_idle_pct;
  logic   tx_hold;
  int     errors, words_in, words_out;

  quaternion_north_vector_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z), .zero_norm(zero_norm),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Rounded k*num/n, ties away from zero, as a 16-bit pattern.
  function automatic logic [15:0] scaled_quotient(longint num, longint k, longint n);
    longint a, q, r;
    a = (num < 0) ? -num : num;
    a = a * k;
    q = a / n;
    r = a % n;
    if (2 * r >= n) q = q + 1;
    if (num < 0) q = -q;
    return q[15:0];
  endfunction

  // Field vector for one quaternion under the current field strength.
  function automatic north_t north_of(quat_t q);
    longint x, y, z, w, n, k;
    north_t r;
    x = q.x; y = q.y; z = q.z; w = q.w;
    n = x * x + y * y + z * z + w * w;
    k = 256 * longint'(field_copy);
    r = '0;
    if (n == 0) begin
      r.zn = 1'b1;
    end else begin
      r.mx = scaled_quotient(2 * (x * y + w * z), k, n);
      r.my = scaled_quotient(w * w + y * y - x * x - z * z, k, n);
      r.mz = scaled_quotient(2 * (y * z - w * x), k, n);
    end
    return r;
  endfunction

  // Driver: one word per handshake, random gaps, optional hold-off.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        words_in <= words_in + 1;
        if (en_copy) north_expected.push_back(north_of({quat_x, quat_y, quat_z, quat_w}));
      end
      if (!tx_hold && quat_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        quat_t q;
        q = quat_pending.pop_front();
        in_valid <= 1'b1;
        quat_x <= q.x; quat_y <= q.y; quat_z <= q.z; quat_w <= q.w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (north_expected.size() == 0) begin
          $error("unexpected result word");
          errors <= errors + 1;
        end else begin
          north_t e;
          int bad;
          e = north_expected.pop_front();
          bad = 0;
          words_out <= words_out + 1;
          if (mag_x !== e.mx) begin
            $error("mag_x expected %0d got %0d", e.mx, mag_x); bad++;
          end
          if (mag_y !== e.my) begin
            $error("mag_y expected %0d got %0d", e.my, mag_y); bad++;
          end
          if (mag_z !== e.mz) begin
            $error("mag_z expected %0d got %0d", e.mz, mag_z); bad++;
          end
          if (zero_norm !== e.zn) begin
            $error("zero_norm expected %0d got %0d", e.zn, zero_norm); bad++;
          end
          errors <= errors + bad;
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Waits until every word is sent and answered, then lets the pipeline settle.
  task automatic drain();
    while (quat_pending.size() > 0 || in_valid || north_expected.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [FieldBits-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgEnable) en_copy = val[0];
    else field_copy = val;
  endtask

  task automatic push_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
    quat_t q;
    q.x = x; q.y = y; q.z = z; q.w = w;
    quat_pending.push_back(q);
  endtask

  // Mostly full-range components, with small values and zeros mixed in.
  task automatic push_random(int count);
    logic [15:0] c[4];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(9))
          0: c[j] = 16'h0000;
          1: c[j] = 16'($signed($urandom_range(8)) - 4);
          2: c[j] = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
          default: c[j] = 16'($urandom());
        endcase
      end
      push_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  task automatic push_directed();
    push_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    push_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    push_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000);
    push_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
    push_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    push_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    push_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
    push_quat(16'h0001, 16'h0000, 16'h0000, 16'h0001);
    push_quat(16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
    push_quat(16'h0001, 16'h0002, 16'h0003, 16'h0004);
    push_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; out_ready = 1'b0; cfg_we = 1'b0; cfg_index = CfgEnable;
    cfg_data = '0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    en_copy = 1'b0; field_copy = FieldReset;
    tx_idle_pct = 27; rx_idle_pct = 49; tx_hold = 1'b0;
    errors = 0; words_in = 0; words_out = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: words are taken and dropped.
    push_directed();
    push_random(10);
    drain();

    // Default field strength, then the lower extreme 0 and a strength of 90.
    write_reg(CfgEnable, 1'b1);
    push_directed();
    drain();
    write_reg(CfgField, 7'd0);
    push_directed();
    drain();
    write_reg(CfgField, 7'd90);
    push_directed();
    push_random(150);
    // Once the queue is sent, hold the sender until every result is back.
    while (quat_pending.size() > 0) @(posedge clk);
    tx_hold = 1'b1;
    while (in_valid || north_expected.size() > 0) @(posedge clk);
    tx_hold = 1'b0;
    push_random(50);
    drain();

    tx_idle_pct = 49; rx_idle_pct = 27;
    write_reg(CfgField, 7'd127);
    push_random(150);
    drain();
    write_reg(CfgField, 7'd1);
    push_random(50);
    drain();
    write_reg(CfgEnable, 1'b0);
    push_random(20);
    drain();

    tx_idle_pct = 0; rx_idle_pct = 0;
    write_reg(CfgEnable, 1'b1);
    write_reg(CfgField, 7'($urandom_range(127)));
    push_random(200);
    drain();

    $display("Sent %0d quaternion words and checked %0d field vectors.", words_in, words_out);
    $display("Covered enable off and on, field strengths 0, 1, 45, 90, 127 and random.");
    if (errors == 0 && north_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/qnv_pkg.sv
rtl/core/qnv_prep.sv
rtl/core/qnv_div_cell.sv
rtl/core/quaternion_north_vector_core.sv
bench/tb_quaternion_north_vector_core.sv
